FILE: src/krpp_pkg.sv
`timescale 1ns / 1ps
// Package for the keyframed rate packet pacer: field widths, codes.
// No dependencies; used by keyframed_rate_packet_pacer.
package krpp_pkg;
   localparam int TimeW  = 64;
   localparam int RateW  = 40;
   localparam int BytesW = 16;
   localparam int TpsW   = 40;
   localparam int NumW   = 59;
   localparam int ProdW  = 56;
   localparam int DivCntW = 6;

   localparam logic [TimeW-1:0] TimeEnd = {TimeW{1'b1}};

   localparam logic [0:0] ActStore = 1'b0;
   localparam logic [0:0] ActNext  = 1'b1;

   localparam logic [1:0] StatPacket = 2'd0;
   localparam logic [1:0] StatFinish = 2'd1;
   localparam logic [1:0] StatStored = 2'd2;
   localparam logic [1:0] StatFull   = 2'd3;

   localparam logic [0:0] RegPacketBytes = 1'b0;
   localparam logic [0:0] RegTicksPerSec = 1'b1;

   typedef struct packed {
      logic [TimeW-1:0] ftime;
      logic [RateW-1:0] frate;
   } frame_type;
endpackage

FILE: src/keyframed_rate_packet_pacer.sv
`timescale 1ns / 1ps
// Keyframed constant-rate packet pacer, top level.
// Depends on krpp_pkg; keyframe table held in an internal synchronous memory.
//
//  channel  dir  handshake              tdata                          tuser
//  req      in   req_tvalid/req_tready  time[63:0] rate[103:64]        action
//  rsp      out  rsp_tvalid/rsp_tready  time[63:0] size[79:64]         status
//  csr      in   csr_we                 csr_wdata (index csr_index)    -
//
// A store moves later entries up in the table memory and writes; a full table is refused.
// A next request takes each keyframe due before the next packet; each one taken sets the
// gap with the 59-step restoring divider (not run when the rate is zero).
// One item at a time; req_tready is high while the sequencer is idle.
// Reset is synchronous; the table memory needs no clearing, a count bounds reads.
// A result waits in the output register while rsp_tready is low.
module keyframed_rate_packet_pacer #(
   parameter int KEYFRAME_DEPTH = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,   // keyframe_time[63:0], keyframe_rate[103:64]
   input  logic [0:0]    req_tuser,   // action[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [79:0]   rsp_tdata,   // packet_time[63:0], packet_size[79:64]
   output logic [1:0]    rsp_tuser,   // status[1:0]
   input  logic          csr_we,
   input  logic [0:0]    csr_index,
   input  logic [39:0]   csr_wdata
);
   localparam int AW = (KEYFRAME_DEPTH > 1) ? $clog2(KEYFRAME_DEPTH) : 1;
   localparam int CW = $clog2(KEYFRAME_DEPTH + 2);
   localparam logic [CW-1:0] Depth = CW'(KEYFRAME_DEPTH);
   localparam int DivCntLast_W = krpp_pkg::DivCntW;
   localparam logic [DivCntLast_W-1:0] DivLast = DivCntLast_W'(krpp_pkg::NumW - 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_INS_RD  = 4'd1;
   localparam logic [3:0] S_INS_CMP = 4'd2;
   localparam logic [3:0] S_INS_PUT = 4'd3;
   localparam logic [3:0] S_NX_RD   = 4'd4;
   localparam logic [3:0] S_NX_EVAL = 4'd5;
   localparam logic [3:0] S_DV_MUL  = 4'd6;
   localparam logic [3:0] S_DV_RUN  = 4'd7;
   localparam logic [3:0] S_OUT     = 4'd8;

   krpp_pkg::frame_type mem [KEYFRAME_DEPTH];
   krpp_pkg::frame_type rd_ff;
   krpp_pkg::frame_type new_ff;
   krpp_pkg::frame_type wr_data;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en;

   logic [3:0]    state_ff;
   logic [CW-1:0] count_ff, cursor_ff, idx_ff;
   logic [krpp_pkg::TimeW-1:0]  cur_time_ff, next_ff, gap_ff;
   logic [krpp_pkg::RateW-1:0]  cur_rate_ff;
   logic [krpp_pkg::BytesW-1:0] pbytes_ff;
   logic [krpp_pkg::TpsW-1:0]   tps_ff;
   logic [krpp_pkg::NumW-1:0]   num_ff;
   logic [krpp_pkg::RateW:0]    rem_ff;
   logic [DivCntLast_W-1:0]     dcnt_ff;
   logic [1:0]                  res_stat_ff;
   logic [krpp_pkg::TimeW-1:0]  res_time_ff;
   logic [krpp_pkg::BytesW-1:0] res_size_ff;
   logic                        rsp_valid_ff;
   logic [1:0]                  rsp_stat_ff;
   logic [79:0]                 rsp_data_ff;

   logic [krpp_pkg::TimeW:0]    sum;
   logic [krpp_pkg::RateW:0]    rem_sh, rem_sub;
   logic                        has_frame;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

   assign sum       = {1'b0, cur_time_ff} + {1'b0, gap_ff};
   assign has_frame = (cursor_ff < count_ff);
   assign rem_sh    = {rem_ff[krpp_pkg::RateW-1:0], num_ff[krpp_pkg::NumW-1]};
   assign rem_sub   = rem_sh - {1'b0, cur_rate_ff};

   always_comb begin
      rd_addr = (state_ff == S_INS_RD) ? AW'(idx_ff - CW'(1)) : AW'(cursor_ff);
      wr_en   = 1'b0;
      wr_addr = AW'(idx_ff);
      wr_data = new_ff;
      if (state_ff == S_INS_PUT) begin
         wr_en = 1'b1;
      end else if (state_ff == S_INS_CMP) begin
         wr_en = 1'b1;
         if (rd_ff.ftime > new_ff.ftime) begin
            wr_data = rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         idx_ff       <= '0;
         cur_time_ff  <= '0;
         cur_rate_ff  <= '0;
         gap_ff       <= '0;
         pbytes_ff    <= 16'd1500;
         tps_ff       <= 40'd1000000000;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               krpp_pkg::RegPacketBytes: pbytes_ff <= csr_wdata[krpp_pkg::BytesW-1:0];
               krpp_pkg::RegTicksPerSec: tps_ff    <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  new_ff.ftime <= req_tdata[63:0];
                  new_ff.frate <= req_tdata[103:64];
                  idx_ff       <= count_ff;
                  res_time_ff  <= '0;
                  res_size_ff  <= '0;
                  if (req_tuser == krpp_pkg::ActNext) begin
                     state_ff <= S_NX_RD;
                  end else if (count_ff >= Depth) begin
                     res_stat_ff <= krpp_pkg::StatFull;
                     state_ff    <= S_OUT;
                  end else if (count_ff == '0) begin
                     state_ff <= S_INS_PUT;
                  end else begin
                     state_ff <= S_INS_RD;
                  end
               end
            end
            S_INS_RD: state_ff <= S_INS_CMP;
            S_INS_CMP: begin
               if (rd_ff.ftime > new_ff.ftime) begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= (idx_ff == CW'(1)) ? S_INS_PUT : S_INS_RD;
               end else begin
                  count_ff    <= count_ff + CW'(1);
                  res_stat_ff <= krpp_pkg::StatStored;
                  state_ff    <= S_OUT;
               end
            end
            S_INS_PUT: begin
               count_ff    <= count_ff + CW'(1);
               res_stat_ff <= krpp_pkg::StatStored;
               state_ff    <= S_OUT;
            end
            S_NX_RD: begin
               next_ff <= sum[krpp_pkg::TimeW] ? krpp_pkg::TimeEnd
                                               : sum[krpp_pkg::TimeW-1:0];
               if (cur_time_ff == krpp_pkg::TimeEnd) begin
                  res_stat_ff <= krpp_pkg::StatFinish;
                  res_time_ff <= krpp_pkg::TimeEnd;
                  state_ff    <= S_OUT;
               end else begin
                  state_ff <= S_NX_EVAL;
               end
            end
            S_NX_EVAL: begin
               if (gap_ff == '0 || (has_frame && rd_ff.ftime < next_ff)) begin
                  if (has_frame) begin
                     cur_time_ff <= rd_ff.ftime;
                     cur_rate_ff <= rd_ff.frate;
                     cursor_ff   <= cursor_ff + CW'(1);
                  end else begin
                     cur_time_ff <= krpp_pkg::TimeEnd;
                     cursor_ff   <= count_ff + CW'(1);
                  end
                  state_ff <= S_DV_MUL;
               end else begin
                  cur_time_ff <= next_ff;
                  res_stat_ff <= krpp_pkg::StatPacket;
                  res_time_ff <= next_ff;
                  res_size_ff <= pbytes_ff;
                  state_ff    <= S_OUT;
               end
            end
            S_DV_MUL: begin
               if (cur_rate_ff == '0) begin
                  gap_ff   <= '0;
                  state_ff <= S_NX_RD;
               end else begin
                  num_ff   <= {krpp_pkg::ProdW'(tps_ff * pbytes_ff), 3'b000};
                  rem_ff   <= '0;
                  dcnt_ff  <= '0;
                  state_ff <= S_DV_RUN;
               end
            end
            S_DV_RUN: begin
               if (rem_sub[krpp_pkg::RateW]) begin
                  rem_ff <= rem_sh;
                  num_ff <= {num_ff[krpp_pkg::NumW-2:0], 1'b0};
               end else begin
                  rem_ff <= rem_sub;
                  num_ff <= {num_ff[krpp_pkg::NumW-2:0], 1'b1};
               end
               dcnt_ff <= dcnt_ff + DivCntLast_W'(1);
               if (dcnt_ff == DivLast) begin
                  gap_ff   <= {5'b0, num_ff[krpp_pkg::NumW-2:0], ~rem_sub[krpp_pkg::RateW]};
                  state_ff <= S_NX_RD;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_stat_ff  <= res_stat_ff;
                  rsp_data_ff  <= {res_size_ff, res_time_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Depth) else $error("keyframe count beyond table depth");
   a_finish_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff == krpp_pkg::StatFinish |->
      rsp_data_ff[63:0] == krpp_pkg::TimeEnd) else $error("finished beat without end time");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DV_RUN |-> dcnt_ff <= DivLast) else $error("divider step count overrun");
   a_nonpacket_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != krpp_pkg::StatPacket |->
      rsp_data_ff[79:64] == '0) else $error("nonzero size on a non-packet beat");
endmodule
